/* hdl/mcc_pkg.sv */
// Package: shared types, constants and command/status structs for the conv block
`default_nettype none
package mcc_pkg;
  localparam int MaxRows = 64;
  localparam int MaxCols = 64;
  localparam int MaxChannels = 4;
  localparam int MaxKernel = 8;
  localparam int RowW = $clog2(MaxRows);
  localparam int ColW = $clog2(MaxCols);
  localparam int ChW = $clog2(MaxChannels);
  localparam int KW = $clog2(MaxKernel);
  localparam int PixAw = ChW + RowW + ColW;
  localparam int WgtAw = ChW + KW + KW;
  localparam int SumW = 48;

  typedef enum logic [1:0] {
    ACT_WEIGHT  = 2'd0,
    ACT_PIXEL   = 2'd1,
    ACT_COMPUTE = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_KERNEL  = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_IMAGE_ROWS = 3'd0,
    REG_IMAGE_COLS = 3'd1,
    REG_KERNEL_ROWS = 3'd2,
    REG_KERNEL_COLS = 3'd3,
    REG_CHANNELS = 3'd4,
    REG_ROW_STRIDE = 3'd5,
    REG_COL_STRIDE = 3'd6,
    REG_BIAS = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_RUN, S_DRAIN, S_OUT
  } state_e;

  typedef struct packed {
    logic latch;
    logic check;
    logic clear;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic       check_ok;
    status_e    status;
    logic       walk_done;
    logic       acc_idle;
  } stat_t;
endpackage
`default_nettype wire

/* hdl/mcc_datapath.sv */
// Datapath: stores, config registers, window walker and the MAC unit
`default_nettype none
module mcc_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_index_i,
  input  logic [31:0]               cfg_data_i,
  input  logic                      wr_en_i,
  input  logic [1:0]                act_i,
  input  logic [1:0]                ch_i,
  input  logic [5:0]                row_i,
  input  logic [5:0]                col_i,
  input  logic signed [15:0]        value_i,
  input  mcc_pkg::cmd_t             cmd_i,
  output mcc_pkg::stat_t            stat_o,
  output logic signed [47:0]        sum_o,
  output logic [1:0]                status_o
);
  import mcc_pkg::*;

  logic [6:0]  irows_q, icols_q;
  logic [3:0]  krows_q, kcols_q, rstr_q, cstr_q;
  logic [2:0]  nch_q;
  logic signed [31:0] bias_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irows_q <= 7'd64; icols_q <= 7'd64; krows_q <= 4'd3; kcols_q <= 4'd3;
      nch_q <= 3'd1; rstr_q <= 4'd1; cstr_q <= 4'd1; bias_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_IMAGE_ROWS:  irows_q <= cfg_data_i[6:0];
        REG_IMAGE_COLS:  icols_q <= cfg_data_i[6:0];
        REG_KERNEL_ROWS: krows_q <= cfg_data_i[3:0];
        REG_KERNEL_COLS: kcols_q <= cfg_data_i[3:0];
        REG_CHANNELS:    nch_q <= cfg_data_i[2:0];
        REG_ROW_STRIDE:  rstr_q <= cfg_data_i[3:0];
        REG_COL_STRIDE:  cstr_q <= cfg_data_i[3:0];
        REG_BIAS:        bias_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [6:0] ir, ic;
  logic [3:0] kr, kc, rs, cs;
  logic [2:0] nc;
  assign ir = (irows_q > 7'(MaxRows)) ? 7'(MaxRows) : irows_q;
  assign ic = (icols_q > 7'(MaxCols)) ? 7'(MaxCols) : icols_q;
  assign kr = (krows_q == 4'd0) ? 4'd1 :
              ((krows_q > 4'(MaxKernel)) ? 4'(MaxKernel) : krows_q);
  assign kc = (kcols_q == 4'd0) ? 4'd1 :
              ((kcols_q > 4'(MaxKernel)) ? 4'(MaxKernel) : kcols_q);
  assign nc = (nch_q == 3'd0) ? 3'd1 :
              ((nch_q > 3'(MaxChannels)) ? 3'(MaxChannels) : nch_q);
  assign rs = (rstr_q == 4'd0) ? 4'd1 : rstr_q;
  assign cs = (cstr_q == 4'd0) ? 4'd1 : cstr_q;

  // stores
  logic signed [15:0] pix_mem [2**PixAw];
  logic signed [15:0] wgt_mem [2**WgtAw];
  always_ff @(posedge clk_i) begin
    if (wr_en_i && act_i == ACT_PIXEL)
      pix_mem[{ch_i, row_i, col_i}] <= value_i;
    if (wr_en_i && act_i == ACT_WEIGHT && row_i < 6'(MaxKernel) && col_i < 6'(MaxKernel))
      wgt_mem[{ch_i, row_i[2:0], col_i[2:0]}] <= value_i;
  end

  // position test: r*rs + kr <= ir, same for col (equivalent to r < (ir-kr)/rs+1)
  logic [5:0] orow_q, ocol_q;
  logic [9:0] r0_q, c0_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      orow_q <= row_i;
      ocol_q <= col_i;
    end
    if (cmd_i.check) begin
      r0_q <= 10'(orow_q * rs);
      c0_q <= 10'(ocol_q * cs);
    end
  end
  logic [10:0] rend, cend;
  assign rend = 11'(r0_q) + 11'(kr);
  assign cend = 11'(c0_q) + 11'(kc);
  always_comb begin
    stat_o.check_ok = 1'b0;
    if ({3'd0, kr} > ir || {3'd0, kc} > ic) stat_o.status = ST_KERNEL;
    else if (rend > 11'(ir) || cend > 11'(ic)) stat_o.status = ST_OUTSIDE;
    else begin
      stat_o.status = ST_OK;
      stat_o.check_ok = 1'b1;
    end
  end

  // window walker
  logic [1:0] k_q;
  logic [2:0] i_q, j_q;
  logic lastk, lasti, lastj;
  assign lastj = ({1'b0, j_q} == kc - 4'd1);
  assign lasti = ({1'b0, i_q} == kr - 4'd1);
  assign lastk = ({1'b0, k_q} == nc - 3'd1);
  assign stat_o.walk_done = lastj && lasti && lastk;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0; i_q <= '0; j_q <= '0;
    end else if (cmd_i.clear) begin
      k_q <= '0; i_q <= '0; j_q <= '0;
    end else if (cmd_i.step) begin
      if (!lastj) j_q <= j_q + 3'd1;
      else begin
        j_q <= '0;
        if (!lasti) i_q <= i_q + 3'd1;
        else begin
          i_q <= '0;
          k_q <= k_q + 2'd1;
        end
      end
    end
  end

  logic [5:0] pr, pc;
  assign pr = 6'(r0_q + 10'(i_q));
  assign pc = 6'(c0_q + 10'(j_q));

  // read stage, multiply stage, accumulate stage
  logic signed [15:0] w_q, p_q;
  logic signed [31:0] prod_q;
  logic rd_v_q, mul_v_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      w_q <= wgt_mem[{k_q, i_q, j_q}];
      p_q <= pix_mem[{k_q, pr, pc}];
    end
    prod_q <= w_q * p_q;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0; mul_v_q <= 1'b0;
    end else begin
      rd_v_q <= cmd_i.step;
      mul_v_q <= rd_v_q;
    end
  end
  assign stat_o.acc_idle = !rd_v_q && !mul_v_q;

  // accumulator and output register
  logic signed [SumW-1:0] acc_q, sum_q;
  logic [1:0] st_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.check) acc_q <= SumW'(bias_q);
    else if (mul_v_q) acc_q <= acc_q + SumW'(prod_q);
    if (cmd_i.finish) begin
      st_q <= stat_o.status;
      sum_q <= (stat_o.status == ST_OK) ? acc_q : '0;
    end
  end
  assign status_o = st_q;
  assign sum_o = sum_q;
endmodule
`default_nettype wire

/* hdl/mcc_ctrl.sv */
// Controller: sequences the check, MAC walk and result handoff
`default_nettype none
module mcc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [1:0]      act_i,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output mcc_pkg::cmd_t   cmd_o,
  input  mcc_pkg::stat_t  stat_i
);
  import mcc_pkg::*;
  state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    s_axis_tready = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && act_i == ACT_COMPUTE) begin
          cmd_o.latch = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        cmd_o.clear = 1'b1;
        state_d = S_RUN;
      end
      S_RUN: begin
        if (!stat_i.check_ok) begin
          if (out_free) begin
            cmd_o.finish = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_OUT;
          end
        end else begin
          cmd_o.step = 1'b1;
          if (stat_i.walk_done) state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (stat_i.acc_idle) begin
          if (out_free) begin
            cmd_o.finish = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (cmd_o.finish) out_valid_d = 1'b1;
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("out hold");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == S_IDLE) else $error("busy accept");
  a_drain_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> stat_i.check_ok) else $error("step bad");
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!m_axis_tvalid || m_axis_tready)) else $error("overwrite");
endmodule
`default_nettype wire

/* hdl/multichannel_conv2d.sv */
// Top level: stream wrapper joining controller and datapath
// Write items are accepted back to back while the block is idle. A compute item
// walks its channels*kernel_rows*kernel_cols window taps with the single MAC unit,
// one tap a cycle, and drains before the next beat is taken; a rejected position
// skips the walk. The result waits in an output register, so the input keeps taking
// beats while it is held; a second result stalls the block until the first is taken.
`default_nettype none
module multichannel_conv2d (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata, // channel, row, col, value, zero fill
  input  logic [1:0]   s_axis_tuser, // action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [55:0]  m_axis_tdata  // conv_sum, status, zero fill
);
  import mcc_pkg::*;
  cmd_t cmd;
  stat_t stat;
  logic signed [47:0] sum;
  logic [1:0] st;

  mcc_ctrl u_ctrl (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
    .act_i(s_axis_tuser), .m_axis_tvalid, .m_axis_tready,
    .cmd_o(cmd), .stat_i(stat)
  );

  mcc_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .wr_en_i(s_axis_tvalid && s_axis_tready),
    .act_i(s_axis_tuser), .ch_i(s_axis_tdata[1:0]),
    .row_i(s_axis_tdata[7:2]), .col_i(s_axis_tdata[13:8]),
    .value_i(s_axis_tdata[29:14]), .cmd_i(cmd), .stat_o(stat),
    .sum_o(sum), .status_o(st)
  );

  assign m_axis_tdata = {6'd0, st, sum};
endmodule
`default_nettype wire

/* dv/tb.sv */
// Stream testbench for the strided multichannel convolution block with its own result predictor
`default_nettype none
module tb;
  import mcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;
  localparam int SettleCycles = 300;

  typedef struct {
    logic [47:0] conv_sum;
    status_e     status;
  } conv_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  multichannel_conv2d dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #1 clk_i = ~clk_i;

  logic signed [15:0] pix_mem [MaxChannels][MaxRows][MaxCols];
  logic signed [15:0] wgt_mem [MaxChannels][MaxKernel][MaxKernel];
  bit pix_wr [MaxChannels][MaxRows][MaxCols];
  bit wgt_wr [MaxChannels][MaxKernel][MaxKernel];

  bit [6:0]  img_rows_q = 7'd64;
  bit [6:0]  img_cols_q = 7'd64;
  bit [3:0]  ker_rows_q = 4'd3;
  bit [3:0]  ker_cols_q = 4'd3;
  bit [2:0]  chan_cnt_q = 3'd1;
  bit [3:0]  row_step_q = 4'd1;
  bit [3:0]  col_step_q = 4'd1;
  bit [31:0] bias_q = '0;

  conv_res_t pending_q[$];
  int mismatches = 0;
  bit tx_no_idle = 1'b0;
  bit rx_no_idle = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_cnt = 0;

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void get_geom(output int ir, ic, kr, kc, nch, rs, cs);
    ir = img_rows_q > MaxRows ? MaxRows : img_rows_q;
    ic = img_cols_q > MaxCols ? MaxCols : img_cols_q;
    kr = clampi(ker_rows_q, 1, MaxKernel);
    kc = clampi(ker_cols_q, 1, MaxKernel);
    nch = clampi(chan_cnt_q, 1, MaxChannels);
    rs = row_step_q == 0 ? 1 : row_step_q;
    cs = col_step_q == 0 ? 1 : col_step_q;
  endfunction

  // output positions along each axis, zero when the kernel does not fit
  function automatic void out_dims(output int orows, ocols);
    int ir, ic, kr, kc, nch, rs, cs;
    get_geom(ir, ic, kr, kc, nch, rs, cs);
    if (kr > ir || kc > ic) begin
      orows = 0;
      ocols = 0;
    end else begin
      orows = (ir - kr) / rs + 1;
      ocols = (ic - kc) / cs + 1;
    end
  endfunction

  function automatic conv_res_t predict_conv(int r, int c);
    int ir, ic, kr, kc, nch, rs, cs;
    longint acc;
    conv_res_t res;
    get_geom(ir, ic, kr, kc, nch, rs, cs);
    acc = 0;
    res.status = ST_OK;
    if (kr > ir || kc > ic) begin
      res.status = ST_KERNEL;
    end else if (r >= (ir - kr) / rs + 1 || c >= (ic - kc) / cs + 1) begin
      res.status = ST_OUTSIDE;
    end else begin
      for (int k = 0; k < nch; k++)
        for (int i = 0; i < kr; i++)
          for (int j = 0; j < kc; j++)
            acc += longint'(wgt_mem[k][i][j]) * longint'(pix_mem[k][r*rs+i][c*cs+j]);
      acc += longint'($signed(bias_q));
    end
    res.conv_sum = res.status == ST_OK ? acc[47:0] : 48'd0;
    return res;
  endfunction

  task automatic wait_drain();
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_beat(action_e act, bit [1:0] ch, bit [5:0] r, bit [5:0] c,
                           bit [15:0] v);
    @(negedge clk_i);
    while (!tx_no_idle && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {2'b00, v, c, r, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    case (act)
      ACT_WEIGHT: begin
        if (r < MaxKernel && c < MaxKernel) begin
          wgt_mem[ch][r][c] = v;
          wgt_wr[ch][r][c] = 1'b1;
        end
      end
      ACT_PIXEL: begin
        pix_mem[ch][r][c] = v;
        pix_wr[ch][r][c] = 1'b1;
      end
      ACT_COMPUTE: pending_q.push_back(predict_conv(r, c));
      default: ;
    endcase
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic set_reg(reg_e idx, bit [31:0] d);
    end_burst();
    wait_drain();
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_IMAGE_ROWS:  img_rows_q = d[6:0];
      REG_IMAGE_COLS:  img_cols_q = d[6:0];
      REG_KERNEL_ROWS: ker_rows_q = d[3:0];
      REG_KERNEL_COLS: ker_cols_q = d[3:0];
      REG_CHANNELS:    chan_cnt_q = d[2:0];
      REG_ROW_STRIDE:  row_step_q = d[3:0];
      REG_COL_STRIDE:  col_step_q = d[3:0];
      default:         bias_q = d;
    endcase
  endtask

  task automatic apply_geom(bit [31:0] ir, ic, kr, kc, nch, rs, cs, b);
    set_reg(REG_IMAGE_ROWS, ir);
    set_reg(REG_IMAGE_COLS, ic);
    set_reg(REG_KERNEL_ROWS, kr);
    set_reg(REG_KERNEL_COLS, kc);
    set_reg(REG_CHANNELS, nch);
    set_reg(REG_ROW_STRIDE, rs);
    set_reg(REG_COL_STRIDE, cs);
    set_reg(REG_BIAS, b);
  endtask

  // write every store entry a compute can reach under the current geometry
  task automatic fill_region();
    int ir, ic, kr, kc, nch, rs, cs;
    get_geom(ir, ic, kr, kc, nch, rs, cs);
    for (int k = 0; k < nch; k++) begin
      for (int i = 0; i < kr; i++)
        for (int j = 0; j < kc; j++)
          if (!wgt_wr[k][i][j])
            send_beat(ACT_WEIGHT, 2'(k), 6'(i), 6'(j), 16'($urandom()));
      for (int i = 0; i < ir; i++)
        for (int j = 0; j < ic; j++)
          if (!pix_wr[k][i][j])
            send_beat(ACT_PIXEL, 2'(k), 6'(i), 6'(j), 16'($urandom()));
    end
  endtask

  // write the entries one compute reads, then send that compute
  task automatic probe(bit [1:0] ch, bit [5:0] r, bit [5:0] c, bit [15:0] v);
    int ir, ic, kr, kc, nch, rs, cs, orows, ocols;
    get_geom(ir, ic, kr, kc, nch, rs, cs);
    out_dims(orows, ocols);
    if (r < orows && c < ocols) begin
      for (int k = 0; k < nch; k++)
        for (int i = 0; i < kr; i++)
          for (int j = 0; j < kc; j++) begin
            if (!wgt_wr[k][i][j])
              send_beat(ACT_WEIGHT, 2'(k), 6'(i), 6'(j), 16'($urandom()));
            if (!pix_wr[k][r*rs+i][c*cs+j])
              send_beat(ACT_PIXEL, 2'(k), 6'(r*rs+i), 6'(c*cs+j), 16'($urandom()));
          end
    end
    send_beat(ACT_COMPUTE, ch, r, c, v);
  endtask

  task automatic probe_corners();
    int orows, ocols;
    out_dims(orows, ocols);
    probe(2'd0, 6'd0, 6'd0, 16'd0);
    if (orows > 0) begin
      probe(2'd0, 6'(orows - 1), 6'(ocols - 1), 16'd0);
      probe(2'd0, 6'(orows), 6'd0, 16'd0);
      probe(2'd0, 6'd0, 6'(ocols), 16'd0);
    end
    probe(2'd3, 6'd63, 6'd63, 16'hffff);
  endtask

  task automatic test_directed();
    probe_corners();
    probe(2'd2, 6'd5, 6'd7, 16'h8000);
    send_beat(ACT_NONE, 2'd3, 6'd0, 6'd0, 16'h1234);
    send_beat(ACT_PIXEL, 2'd0, 6'd0, 6'd0, 16'h8000);
    send_beat(ACT_PIXEL, 2'd0, 6'd0, 6'd1, 16'h7fff);
    send_beat(ACT_WEIGHT, 2'd0, 6'd0, 6'd0, 16'h8000);
    send_beat(ACT_WEIGHT, 2'd0, 6'd0, 6'd1, 16'h8000);
    send_beat(ACT_WEIGHT, 2'd0, 6'd8, 6'd0, 16'h5555);
    send_beat(ACT_WEIGHT, 2'd0, 6'd0, 6'd9, 16'haaaa);
    send_beat(ACT_WEIGHT, 2'd0, 6'd15, 6'd15, 16'h7fff);
    probe(2'd0, 6'd0, 6'd0, 16'd0);
    probe(2'd1, 6'd0, 6'd1, 16'h7fff);
    end_burst();
  endtask

  task automatic test_config_extremes();
    apply_geom(8, 8, 8, 8, 4, 1, 1, 32'h7fffffff);
    probe_corners();
    apply_geom(64, 64, 8, 8, 1, 8, 8, 32'h80000000);
    probe_corners();
    apply_geom(127, 127, 15, 15, 1, 0, 0, 32'hffffffff);
    probe_corners();
    apply_geom(0, 5, 1, 1, 1, 1, 1, 32'h00010000);
    probe_corners();
    apply_geom(2, 2, 3, 3, 7, 15, 15, 32'h1);
    probe_corners();
    apply_geom(1, 1, 0, 0, 0, 1, 1, 32'hfffe0000);
    probe_corners();
    apply_geom(64, 1, 1, 1, 4, 3, 1, 32'h0);
    probe_corners();
    end_burst();
  endtask

  task automatic random_geom();
    bit [31:0] ir, ic, kr, kc, nch, rs, cs;
    ir = $urandom_range(1, 12);
    ic = $urandom_range(1, 12);
    kr = $urandom_range(1, 4);
    kc = $urandom_range(1, 4);
    nch = $urandom_range(1, 4);
    rs = $urandom_range(1, 3);
    cs = $urandom_range(1, 3);
    if ($urandom_range(5) == 0) kr = $urandom_range(0, 15);
    if ($urandom_range(5) == 0) nch = $urandom_range(0, 7);
    if ($urandom_range(5) == 0) rs = $urandom_range(0, 15);
    if ($urandom_range(5) == 0) cs = $urandom_range(0, 15);
    apply_geom(ir, ic, kr, kc, nch, rs, cs, $urandom());
  endtask

  task automatic random_beat();
    int orows, ocols, roll;
    bit [5:0] r, c;
    out_dims(orows, ocols);
    roll = $urandom_range(99);
    if (roll < 30) begin
      send_beat(ACT_WEIGHT, 2'($urandom()), 6'($urandom_range(0, 9)),
                6'($urandom_range(0, 9)), 16'($urandom()));
    end else if (roll < 58) begin
      send_beat(ACT_PIXEL, 2'($urandom()), 6'($urandom()), 6'($urandom()),
                16'($urandom()));
    end else if (roll < 95) begin
      r = 6'($urandom());
      c = 6'($urandom());
      if (orows > 0 && $urandom_range(3) != 0) begin
        r = 6'($urandom_range(0, orows));
        c = 6'($urandom_range(0, ocols));
      end
      send_beat(ACT_COMPUTE, 2'($urandom()), r, c, 16'($urandom()));
    end else begin
      send_beat(ACT_NONE, 2'($urandom()), 6'($urandom()), 6'($urandom()),
                16'($urandom()));
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 8; ph++) begin
      random_geom();
      tx_no_idle = ph == 3;
      rx_no_idle = ph == 3;
      fill_region();
      repeat (60) random_beat();
      end_burst();
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    apply_geom(4, 4, 2, 2, 2, 1, 1, $urandom());
    fill_region();
    hold_req = 1'b1;
    repeat (30)
      send_beat(ACT_COMPUTE, 2'd0, 6'($urandom_range(0, 3)), 6'($urandom_range(0, 3)),
                16'd0);
    end_burst();
    repeat (10) random_beat();
    end_burst();
    wait_drain();
    repeat (10) random_beat();
    end_burst();
  endtask

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 3000;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rx_no_idle || $urandom_range(99) >= 23;
    end
  end

  always @(posedge clk_i) begin
    conv_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: sum=%h status=%0d",
                   m_axis_tdata[47:0], m_axis_tdata[49:48]);
      end else begin
        want = pending_q.pop_front();
        if (m_axis_tdata[47:0] !== want.conv_sum || m_axis_tdata[49:48] !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: sum exp=%h act=%h status exp=%0d act=%0d",
                     want.conv_sum, m_axis_tdata[47:0], want.status, m_axis_tdata[49:48]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      stall_cnt = 0;
    else
      stall_cnt++;
    if (stall_cnt >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_config_extremes();
    test_random();
    test_backpressure();
    wait_drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* multichannel_conv2d.f */
hdl/mcc_pkg.sv
hdl/mcc_datapath.sv
hdl/mcc_ctrl.sv
hdl/multichannel_conv2d.sv
dv/tb.sv
